// ===== rtl/display_switch_settle_watch_defines.svh =====
// display_switch_settle_watch_defines.svh: assertion macros for the settle watch block
// no dependencies; included by the files that carry assertions
`ifndef DISPLAY_SWITCH_SETTLE_WATCH_DEFINES_SVH
`define DISPLAY_SWITCH_SETTLE_WATCH_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define DSW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dsw_pkg.sv =====
// dsw_pkg: types and constants of the display switch settle watch block
// no dependencies; used by display_switch_settle_watch
package dsw_pkg;

    // item kinds carried on the slave-side tuser
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_ROUND  = 2'd3
    } t_opcode;

    // configuration register indexes
    localparam logic [2:0] CFG_BUSY_AFTER  = 3'd0;
    localparam logic [2:0] CFG_READY_FLOOR = 3'd1;
    localparam logic [2:0] CFG_READY_MAX   = 3'd2;
    localparam logic [2:0] CFG_RETRY       = 3'd3;
    localparam logic [2:0] CFG_MAX_RETRIES = 3'd4;

    // field widths
    localparam int TIME_W   = 18;
    localparam int CODE_W   = 8;
    localparam int INDEX_W  = 4;
    localparam int RETRY_W  = 3;
    localparam int CNT_W    = 5;
    localparam int CFG_IDX_W = 3;

    // configuration reset values
    localparam logic [TIME_W-1:0]  RST_BUSY_AFTER  = 18'd3000;
    localparam logic [TIME_W-1:0]  RST_READY_FLOOR = 18'd5000;
    localparam logic [TIME_W-1:0]  RST_READY_MAX   = 18'd8000;
    localparam logic [TIME_W-1:0]  RST_RETRY       = 18'd20000;
    localparam logic [RETRY_W-1:0] RST_MAX_RETRIES = 3'd2;

    // input transaction payload, first field in the highest bits
    typedef struct packed {
        logic [TIME_W-1:0] elapsed_ms;
        logic              signal_present;
        logic              timing_ok;
        logic [CODE_W-1:0] reported_input;
        logic              input_ok;
        logic [CODE_W-1:0] watch_code;
        logic [INDEX_W-1:0] monitor_index;
    } t_in_item;

    localparam int IN_BITS     = $bits(t_in_item);
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // result transaction payload, first field in the highest bits
    typedef struct packed {
        logic             monitor_locked;
        logic             monitor_ready;
        logic             monitor_watched;
        logic [CNT_W-1:0] unready_count;
        logic [CNT_W-1:0] pending_count;
        logic             gave_up;
        logic             finished;
        logic             acquire;
    } t_result;

    localparam int OUT_TDATA_W = $bits(t_result);

    // marks of one display
    typedef struct packed {
        logic watched;
        logic clean;
        logic busy;
        logic ready;
        logic locked;
    } t_marks;

endpackage

// ===== rtl/display_switch_settle_watch.sv =====
// display_switch_settle_watch: settle watch over the displays after an input switch
// depends on dsw_pkg and display_switch_settle_watch_defines.svh
// Usage
//   Slave stream: one transaction per item; tuser[1:0] is the item kind (clear, load,
//   sample, round), tdata carries the display index, watch code, query replies and time.
//   Master stream: exactly one result transaction per item, in order.
//   Config port: i_cfg_wr_en writes i_cfg_data into register i_cfg_index at the edge;
//   write only while no item is in flight.
// Pipeline and throughput
//   An accepted item enters the input register; once the output register can take it,
//   its result is registered there and shows on the master side.
//   One item per cycle sustained while the master side takes results: the per-display
//   marks change at one index per item and the pending and unready counts are kept as
//   running counters, so nothing scans the display table.
// Reset
//   Registers take their reset values, all marks and round state clear, watch codes are
//   undefined until a load writes them.
// Stall
//   When the master side stalls, the result holds, the input register holds its item
//   and tready drops while that item waits; nothing is lost or repeated.
`include "display_switch_settle_watch_defines.svh"

module display_switch_settle_watch #(
    parameter int MONITORS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: monitor_index, watch_code, input_ok, reported_input, timing_ok,
    //        signal_present, elapsed_ms, zero fill
    input  logic [dsw_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: opcode
    input  logic [1:0]                      i_s_axis_tuser,
    // master side
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: acquire, finished, gave_up, pending_count, unready_count,
    //        monitor_watched, monitor_ready, monitor_locked
    output logic [dsw_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [dsw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dsw_pkg::TIME_W-1:0]      i_cfg_data
);

    // only the displays reachable by the index field get storage
    localparam int DEPTH  = (MONITORS < (1 << dsw_pkg::INDEX_W)) ? MONITORS
                                                                : (1 << dsw_pkg::INDEX_W);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [6:0] MON_LIMIT = 7'(MONITORS);

    // configuration registers
    logic [dsw_pkg::TIME_W-1:0]  r_busy_after_ms;
    logic [dsw_pkg::TIME_W-1:0]  r_ready_floor_ms;
    logic [dsw_pkg::TIME_W-1:0]  r_ready_max_ms;
    logic [dsw_pkg::TIME_W-1:0]  r_retry_ms;
    logic [dsw_pkg::RETRY_W-1:0] r_max_retries;

    // input register
    logic                r_in_valid;
    dsw_pkg::t_opcode    r_in_op;
    dsw_pkg::t_in_item   r_in;

    // output register
    logic                r_out_valid;
    dsw_pkg::t_result    r_out;
    dsw_pkg::t_result    n_out;

    // per-display state
    logic [dsw_pkg::CODE_W-1:0] r_code [DEPTH];
    logic [DEPTH-1:0]           r_watched;
    logic [DEPTH-1:0]           r_clean;
    logic [DEPTH-1:0]           r_busy;
    logic [DEPTH-1:0]           r_ready;
    logic [DEPTH-1:0]           r_locked;

    // round state and running counts
    logic                        r_acquired_once, n_acquired_once;
    logic [dsw_pkg::TIME_W-1:0]  r_last_acquire,  n_last_acquire;
    logic [dsw_pkg::RETRY_W-1:0] r_retry_count,   n_retry_count;
    logic                        r_any_watched,   n_any_watched;
    logic                        r_done,          n_done;
    logic [dsw_pkg::CNT_W-1:0]   r_pending,       n_pending;
    logic [dsw_pkg::CNT_W-1:0]   r_unready,       n_unready;

    logic                        w_advance;
    logic                        w_in_range;
    logic [IDX_W-1:0]            w_sel;
    logic                        w_mark_wr;
    dsw_pkg::t_marks             w_cur;
    dsw_pkg::t_marks             n_mark;
    logic [dsw_pkg::TIME_W-1:0]  w_since;

    // handshake: the input register moves on whenever the output register can take a result
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_after_ms  <= dsw_pkg::RST_BUSY_AFTER;
            r_ready_floor_ms <= dsw_pkg::RST_READY_FLOOR;
            r_ready_max_ms   <= dsw_pkg::RST_READY_MAX;
            r_retry_ms       <= dsw_pkg::RST_RETRY;
            r_max_retries    <= dsw_pkg::RST_MAX_RETRIES;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                dsw_pkg::CFG_BUSY_AFTER:  r_busy_after_ms  <= i_cfg_data;
                dsw_pkg::CFG_READY_FLOOR: r_ready_floor_ms <= i_cfg_data;
                dsw_pkg::CFG_READY_MAX:   r_ready_max_ms   <= i_cfg_data;
                dsw_pkg::CFG_RETRY:       r_retry_ms       <= i_cfg_data;
                dsw_pkg::CFG_MAX_RETRIES: r_max_retries    <= i_cfg_data[dsw_pkg::RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_op <= dsw_pkg::t_opcode'(i_s_axis_tuser);
            r_in    <= dsw_pkg::t_in_item'(i_s_axis_tdata[dsw_pkg::IN_BITS-1:0]);
        end
    end

    // addressed display and its current marks
    assign w_in_range = ({3'b000, r_in.monitor_index} < MON_LIMIT);
    assign w_sel      = r_in.monitor_index[IDX_W-1:0];

    always_comb begin
        w_cur.watched = r_watched[w_sel];
        w_cur.clean   = r_clean[w_sel];
        w_cur.busy    = r_busy[w_sel];
        w_cur.ready   = r_ready[w_sel];
        w_cur.locked  = r_locked[w_sel];
    end

    // mark update for a clear, load or sample of the addressed display
    always_comb begin
        n_mark    = w_cur;
        w_mark_wr = 1'b0;
        unique case (r_in_op)
            dsw_pkg::OP_CLEAR: begin
                n_mark = '0;
            end
            dsw_pkg::OP_LOAD: begin
                if (!r_done && w_in_range) begin
                    w_mark_wr      = 1'b1;
                    n_mark         = '0;
                    n_mark.watched = 1'b1;
                end
            end
            dsw_pkg::OP_SAMPLE: begin
                if (!r_done && w_in_range && w_cur.watched && !w_cur.locked) begin
                    w_mark_wr = 1'b1;
                    if (r_in.input_ok && (r_in.reported_input != r_code[w_sel])) begin
                        // foreign input: stop watching
                        n_mark.watched = 1'b0;
                    end else if (r_in.timing_ok && r_in.signal_present) begin
                        n_mark.locked = 1'b1;
                        n_mark.ready  = 1'b1;
                    end else if (!w_cur.ready) begin
                        if (!r_in.input_ok || !r_in.timing_ok) begin
                            if (w_cur.clean && (r_in.elapsed_ms >= r_busy_after_ms)) begin
                                n_mark.busy = 1'b1;
                            end
                        end else if (w_cur.busy || (r_in.elapsed_ms >= r_ready_floor_ms)) begin
                            n_mark.ready = 1'b1;
                        end else begin
                            n_mark.clean = 1'b1;
                        end
                    end
                end
            end
            dsw_pkg::OP_ROUND: ;
            default: ;
        endcase
    end

    // running counts and round decision
    always_comb begin
        n_acquired_once = r_acquired_once;
        n_last_acquire  = r_last_acquire;
        n_retry_count   = r_retry_count;
        n_any_watched   = r_any_watched;
        n_done          = r_done;
        n_pending       = r_pending;
        n_unready       = r_unready;
        n_out           = '0;
        w_since         = '0;

        if (r_in_op == dsw_pkg::OP_CLEAR) begin
            n_acquired_once = 1'b0;
            n_last_acquire  = '0;
            n_retry_count   = '0;
            n_any_watched   = 1'b0;
            n_done          = 1'b0;
            n_pending       = '0;
            n_unready       = '0;
        end else if (w_mark_wr) begin
            // swap the old contribution of the display for the new one
            n_pending = r_pending
                      - dsw_pkg::CNT_W'(w_cur.watched && !w_cur.locked)
                      + dsw_pkg::CNT_W'(n_mark.watched && !n_mark.locked);
            n_unready = r_unready
                      - dsw_pkg::CNT_W'(w_cur.watched && !w_cur.ready)
                      + dsw_pkg::CNT_W'(n_mark.watched && !n_mark.ready);
            if (r_in_op == dsw_pkg::OP_LOAD) begin
                n_any_watched = 1'b1;
            end
        end

        // end of round
        if (r_in_op == dsw_pkg::OP_ROUND && !r_done) begin
            if (!r_acquired_once) begin
                if ((n_pending == '0) && r_any_watched) begin
                    n_done = 1'b1;
                end else if ((n_unready == '0) || (r_in.elapsed_ms >= r_ready_max_ms)) begin
                    n_out.acquire   = 1'b1;
                    n_acquired_once = 1'b1;
                    n_last_acquire  = r_in.elapsed_ms;
                end
            end else if (n_pending != '0) begin
                w_since = (r_in.elapsed_ms >= r_last_acquire) ?
                          (r_in.elapsed_ms - r_last_acquire) : '0;
                if (w_since >= r_retry_ms) begin
                    if (r_retry_count == r_max_retries) begin
                        n_done = 1'b1;
                    end else begin
                        n_retry_count  = r_retry_count + 1'b1;
                        n_out.acquire  = 1'b1;
                        n_last_acquire = r_in.elapsed_ms;
                    end
                end
            end
            if ((n_pending == '0) && n_acquired_once) begin
                n_done = 1'b1;
            end
        end

        n_out.finished        = n_done;
        n_out.gave_up         = n_done && (n_pending != '0);
        n_out.pending_count   = n_pending;
        n_out.unready_count   = n_unready;
        n_out.monitor_watched = w_in_range && n_mark.watched;
        n_out.monitor_ready   = w_in_range && n_mark.ready;
        n_out.monitor_locked  = w_in_range && n_mark.locked;
    end

    // per-display marks and round state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_watched       <= '0;
            r_clean         <= '0;
            r_busy          <= '0;
            r_ready         <= '0;
            r_locked        <= '0;
            r_acquired_once <= 1'b0;
            r_last_acquire  <= '0;
            r_retry_count   <= '0;
            r_any_watched   <= 1'b0;
            r_done          <= 1'b0;
            r_pending       <= '0;
            r_unready       <= '0;
        end else if (w_advance) begin
            if (r_in_op == dsw_pkg::OP_CLEAR) begin
                r_watched <= '0;
                r_clean   <= '0;
                r_busy    <= '0;
                r_ready   <= '0;
                r_locked  <= '0;
            end else if (w_mark_wr) begin
                r_watched[w_sel] <= n_mark.watched;
                r_clean[w_sel]   <= n_mark.clean;
                r_busy[w_sel]    <= n_mark.busy;
                r_ready[w_sel]   <= n_mark.ready;
                r_locked[w_sel]  <= n_mark.locked;
            end
            r_acquired_once <= n_acquired_once;
            r_last_acquire  <= n_last_acquire;
            r_retry_count   <= n_retry_count;
            r_any_watched   <= n_any_watched;
            r_done          <= n_done;
            r_pending       <= n_pending;
            r_unready       <= n_unready;
        end
    end

    // watch codes, written by load items
    always_ff @(posedge i_clk) begin
        if (w_advance && w_mark_wr && (r_in_op == dsw_pkg::OP_LOAD)) begin
            r_code[w_sel] <= r_in.watch_code;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    // checks
    `DSW_ASSERT_NEXT(a_acquire_round_only, i_clk, i_rst_n,
        w_advance && (r_in_op != dsw_pkg::OP_ROUND), !r_out.acquire,
        "acquire raised by an item that is not a round")
    `DSW_ASSERT_NOW(a_unready_within_pending, i_clk, i_rst_n,
        1'b1, r_unready <= r_pending,
        "more unready displays than pending ones")
    `DSW_ASSERT_NEXT(a_clear_restarts, i_clk, i_rst_n,
        w_advance && (r_in_op == dsw_pkg::OP_CLEAR),
        (r_pending == '0) && (r_unready == '0) && !r_done && !r_acquired_once,
        "clear left tracking state behind")
    `DSW_ASSERT_NEXT(a_done_freezes, i_clk, i_rst_n,
        w_advance && r_done && (r_in_op != dsw_pkg::OP_CLEAR),
        r_done && $stable(r_pending) && $stable(r_unready) && !r_out.acquire,
        "tracking state moved after finishing")

endmodule
